### rtl/pbb_pkg.sv
// pbb_pkg: shared types, codes and default sizes for the page bitmap blitter
// used by pbb_seq, pbb_lane and page_bitmap_blit; no dependencies
package pbb_pkg;

   // default buffer geometry
   localparam int COLUMNS_DEF  = 128;
   localparam int PAGES_DEF    = 8;
   localparam int PIX_PER_BYTE = 8;

   // internal widths: column base reaches start + 8*30 + 7, page reaches 23
   localparam int BASE_W = 9;
   localparam int PAGE_W = 5;

   // item kinds (kind 3 is unused and answers ok)
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_WIDTH = 2'd1,
      ST_CLIPPED   = 2'd2,
      ST_NO_BLIT   = 2'd3
   } status_type;

   // command broadcast from the sequencer to every lane
   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic              rd_en;
      logic [BASE_W-1:0] base;
      logic [PAGE_W-1:0] page;
      logic [7:0]        mask;
      logic [7:0]        data;
   } lane_cmd_type;

   // per-item result info from the sequencer to the merge stage
   typedef struct packed {
      status_type status;
      logic       done;
      logic       chk_clip;
      logic       rd_ok;
      logic [2:0] rd_bank;
   } item_info_type;

endpackage

### rtl/page_bitmap_blit.sv
// page_bitmap_blit: top level, eight column-bank lanes, merge and result stages
// depends on pbb_pkg, pbb_seq and pbb_lane
//
//   channel  prefix  direction  handshake      moves
//   request  req_    in         valid / stall  one item word
//   result   rsp_    out        valid / stall  one result word
//   control  csr_    in         valid / ready  flip_mode register
//
// one item word per cycle unless stalled; results go via s1 to the rsp register
// column byte c lives in bank c mod 8, so a data word updates eight banks at once
// reset clears the buffer by sweeping all PAGES * ceil(COLUMNS/8) bank rows
// (128 by default), during which req_stall stays high
// rsp_stall holds the result register and the stage behind it, then req_stall
module page_bitmap_blit #(
   parameter int COLUMNS = pbb_pkg::COLUMNS_DEF,
   parameter int PAGES   = pbb_pkg::PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [6:0] req_x_pos,
   input  logic [5:0] req_y_pos,
   input  logic [7:0] req_width_pixels,
   input  logic [6:0] req_row_count,
   input  logic       req_invert_pixels,
   input  logic [7:0] req_data_byte,
   input  logic [2:0] req_read_page,
   input  logic [6:0] req_read_column,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_read_data,
   output logic       rsp_blit_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_flip_mode
);

   localparam int COL_WORDS = (COLUMNS + 7) / 8;
   localparam int DEPTH     = PAGES * COL_WORDS;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LANES     = pbb_pkg::PIX_PER_BYTE;

   logic                   accept;
   logic                   clearing;
   logic                   flip_ff;
   pbb_pkg::lane_cmd_type  cmd;
   pbb_pkg::item_info_type info;
   logic [ADDR_W-1:0]      clr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [LANES-1:0]       lane_clip;
   logic [7:0]             lane_rd [LANES];
   pbb_pkg::status_type    item_status;

   logic                   s1_valid_ff, s1_valid_in;
   pbb_pkg::status_type    s1_status_ff;
   logic                   s1_done_ff;
   logic                   s1_rd_ok_ff;
   logic [2:0]             s1_bank_ff;
   logic                   out_free;
   logic                   s1_move;

   logic                   rsp_valid_ff, rsp_valid_in;
   pbb_pkg::status_type    rsp_status_ff;
   logic [7:0]             rsp_read_data_ff;
   logic                   rsp_blit_done_ff;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = clearing || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   // control register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         flip_ff <= csr_flip_mode;
      end
   end

   // sequencer
   pbb_seq #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (req_kind),
      .x_pos         (req_x_pos),
      .y_pos         (req_y_pos),
      .width_pixels  (req_width_pixels),
      .row_count     (req_row_count),
      .invert_pixels (req_invert_pixels),
      .data_byte     (req_data_byte),
      .read_page     (req_read_page),
      .read_column   (req_read_column),
      .flip_mode     (flip_ff),
      .cmd           (cmd),
      .clr_addr      (clr_addr),
      .rd_addr       (rd_addr),
      .info          (info),
      .clearing      (clearing)
   );

   // column-bank lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      pbb_lane #(
         .COLUMNS (COLUMNS),
         .PAGES   (PAGES),
         .LANE    (g)
      ) u_lane (
         .clock    (clock),
         .cmd      (cmd),
         .clr_addr (clr_addr),
         .rd_addr  (rd_addr),
         .clip     (lane_clip[g]),
         .rd_data  (lane_rd[g])
      );
   end

   // merge lane clip flags into the item status
   assign item_status = (info.chk_clip && (|lane_clip)) ? pbb_pkg::ST_CLIPPED : info.status;

   // stage beside the bank read registers
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= item_status;
         s1_done_ff   <= info.done;
         s1_rd_ok_ff  <= info.rd_ok;
         s1_bank_ff   <= info.rd_bank;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_status_ff    <= s1_status_ff;
         rsp_read_data_ff <= s1_rd_ok_ff ? lane_rd[s1_bank_ff] : 8'd0;
         rsp_blit_done_ff <= s1_done_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_blit_done = rsp_blit_done_ff;

   // checks
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request taken before the buffer clear finished");

   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("result stage lost a word");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_blit_done_ff |->
         rsp_read_data_ff == 8'd0 && rsp_status_ff != pbb_pkg::ST_NO_BLIT &&
         rsp_status_ff != pbb_pkg::ST_BAD_WIDTH)
      else $error("blit done flagged on a word that is not a data word");

   a_no_blit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == pbb_pkg::ST_NO_BLIT |->
         rsp_read_data_ff == 8'd0 && !rsp_blit_done_ff)
      else $error("no-blit result carries data");

endmodule

### rtl/pbb_lane.sv
// pbb_lane: one column bank of the frame buffer plus its pixel write lane
// depends on pbb_pkg (lane_cmd_type, widths)
module pbb_lane #(
   parameter int COLUMNS = pbb_pkg::COLUMNS_DEF,
   parameter int PAGES   = pbb_pkg::PAGES_DEF,
   parameter int LANE    = 0,
   localparam int COL_WORDS = (COLUMNS + 7) / 8,
   localparam int DEPTH     = PAGES * COL_WORDS,
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  pbb_pkg::lane_cmd_type cmd,
   input  logic [ADDR_W-1:0]    clr_addr,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic                 clip,
   output logic [7:0]           rd_data
);

   localparam int PROD_W = pbb_pkg::PAGE_W + pbb_pkg::BASE_W - 3;
   localparam logic [2:0] LANE_IDX = 3'(LANE);

   logic [7:0]                  mem [DEPTH];
   logic [2:0]                  offset;
   logic [pbb_pkg::BASE_W-1:0]  col;
   logic                        in_range;
   logic [PROD_W-1:0]           prod;
   logic [ADDR_W-1:0]           wr_addr;
   logic                        pix;
   logic [7:0]                  rd_data_ff;

   // this bank's column among the eight the word covers
   always_comb begin
      offset   = LANE_IDX - cmd.base[2:0];
      col      = cmd.base + pbb_pkg::BASE_W'(offset);
      in_range = (col < pbb_pkg::BASE_W'(COLUMNS)) &&
                 (cmd.page < pbb_pkg::PAGE_W'(PAGES));
      prod     = PROD_W'(cmd.page) * PROD_W'(COL_WORDS) +
                 PROD_W'(col[pbb_pkg::BASE_W-1:3]);
      wr_addr  = prod[ADDR_W-1:0];
      pix      = cmd.data[3'd7 - offset];
   end

   assign clip = cmd.wr_en && !in_range;

   // bank write: clearing sweep or single bit-row update
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_addr] <= '0;
      end else if (cmd.wr_en && in_range) begin
         for (int k = 0; k < 8; k++) begin
            if (cmd.mask[k]) begin
               mem[wr_addr][k] <= pix;
            end
         end
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pbb_seq.sv
// pbb_seq: blit state, item decode, lane command and buffer clearing sweep
// depends on pbb_pkg (kind, status, lane command and info types)
module pbb_seq #(
   parameter int COLUMNS = pbb_pkg::COLUMNS_DEF,
   parameter int PAGES   = pbb_pkg::PAGES_DEF,
   localparam int COL_WORDS = (COLUMNS + 7) / 8,
   localparam int DEPTH     = PAGES * COL_WORDS,
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            kind,
   input  logic [6:0]            x_pos,
   input  logic [5:0]            y_pos,
   input  logic [7:0]            width_pixels,
   input  logic [6:0]            row_count,
   input  logic                  invert_pixels,
   input  logic [7:0]            data_byte,
   input  logic [2:0]            read_page,
   input  logic [6:0]            read_column,
   input  logic                  flip_mode,
   output pbb_pkg::lane_cmd_type  cmd,
   output logic [ADDR_W-1:0]     clr_addr,
   output logic [ADDR_W-1:0]     rd_addr,
   output pbb_pkg::item_info_type info,
   output logic                  clearing
);

   localparam int BW     = pbb_pkg::BASE_W;
   localparam int PW     = pbb_pkg::PAGE_W;
   localparam int PROD_W = PW + BW - 3;

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              active_ff, active_in;
   logic [6:0]        start_col_ff, start_col_in;
   logic [BW-1:0]     base_ff, base_in;
   logic [PW-1:0]     page_ff, page_in;
   logic [2:0]        bit_row_ff, bit_row_in;
   logic [4:0]        bpr_ff, bpr_in;
   logic [4:0]        bir_ff, bir_in;
   logic [6:0]        rows_ff, rows_in;
   logic              invert_ff, invert_in;
   logic [2:0]        pos;
   logic              row_end;
   logic [PROD_W-1:0] rd_prod;

   // clearing sweep over every bank row after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   // read address, shared by all banks
   always_comb begin
      rd_prod = PROD_W'(read_page) * PROD_W'(COL_WORDS) + PROD_W'(read_column[6:3]);
      rd_addr = rd_prod[ADDR_W-1:0];
   end

   // bit row inside the column byte, mirrored in flip mode
   always_comb begin
      pos     = flip_mode ? (3'd7 - bit_row_ff) : bit_row_ff;
      row_end = ({1'b0, bir_ff} + 6'd1) >= {1'b0, bpr_ff};
   end

   // item decode and blit state update
   always_comb begin
      active_in    = active_ff;
      start_col_in = start_col_ff;
      base_in      = base_ff;
      page_in      = page_ff;
      bit_row_in   = bit_row_ff;
      bpr_in       = bpr_ff;
      bir_in       = bir_ff;
      rows_in      = rows_ff;
      invert_in    = invert_ff;

      info.status   = pbb_pkg::ST_OK;
      info.done     = 1'b0;
      info.chk_clip = 1'b0;
      info.rd_ok    = 1'b0;
      info.rd_bank  = read_column[2:0];

      cmd.clear = clearing_ff;
      cmd.wr_en = 1'b0;
      cmd.rd_en = accept;
      cmd.base  = base_ff;
      cmd.page  = page_ff;
      cmd.mask  = 8'h01 << pos;
      cmd.data  = data_byte ^ {8{invert_ff}};

      if (accept) begin
         case (kind)
            pbb_pkg::KIND_START: begin
               if (width_pixels[2:0] != 3'd0) begin
                  info.status = pbb_pkg::ST_BAD_WIDTH;
                  active_in   = 1'b0;
               end else begin
                  start_col_in = x_pos;
                  base_in      = BW'(x_pos);
                  page_in      = PW'(y_pos[5:3]);
                  bit_row_in   = y_pos[2:0];
                  bpr_in       = width_pixels[7:3];
                  bir_in       = 5'd0;
                  rows_in      = row_count;
                  invert_in    = invert_pixels;
                  active_in    = (width_pixels != 8'd0) && (row_count != 7'd0);
               end
            end
            pbb_pkg::KIND_DATA: begin
               if (!active_ff) begin
                  info.status = pbb_pkg::ST_NO_BLIT;
               end else begin
                  cmd.wr_en     = 1'b1;
                  info.chk_clip = 1'b1;
                  if (row_end) begin
                     bir_in     = 5'd0;
                     base_in    = BW'(start_col_ff);
                     bit_row_in = bit_row_ff + 3'd1;
                     if (bit_row_ff == 3'd7 && page_ff != '1) begin
                        page_in = page_ff + 1'b1;
                     end
                     rows_in = rows_ff - 7'd1;
                     if (rows_ff == 7'd1) begin
                        active_in = 1'b0;
                        info.done = 1'b1;
                     end
                  end else begin
                     bir_in  = bir_ff + 5'd1;
                     base_in = base_ff + BW'(pbb_pkg::PIX_PER_BYTE);
                  end
               end
            end
            pbb_pkg::KIND_READ: begin
               if ((PW'(read_page) >= PW'(PAGES)) || (BW'(read_column) >= BW'(COLUMNS))) begin
                  info.status = pbb_pkg::ST_CLIPPED;
               end else begin
                  info.rd_ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         active_ff    <= 1'b0;
         start_col_ff <= '0;
         base_ff      <= '0;
         page_ff      <= '0;
         bit_row_ff   <= '0;
         bpr_ff       <= '0;
         bir_ff       <= '0;
         rows_ff      <= '0;
         invert_ff    <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         active_ff    <= active_in;
         start_col_ff <= start_col_in;
         base_ff      <= base_in;
         page_ff      <= page_in;
         bit_row_ff   <= bit_row_in;
         bpr_ff       <= bpr_in;
         bir_ff       <= bir_in;
         rows_ff      <= rows_in;
         invert_ff    <= invert_in;
      end
   end

   assign clr_addr = clr_cnt_ff;
   assign clearing = clearing_ff;

endmodule

### test/tb_top.sv
// tb_top: self-checking bench for page_bitmap_blit, driving blit, data and read-back words
// depends on pbb_pkg and the page_bitmap_blit rtl; results are checked against an internal
// copy of the frame buffer and blit state, through a directed table and then random phases
`timescale 1ns / 1ps

module tb_top;

   // kind 3 has no member in the package enum
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int PHASES = 7;
   localparam int PHASE_WORDS = 200;
   localparam int LONG_HOLD = 120;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] x_pos;
      logic [5:0] y_pos;
      logic [7:0] width_pixels;
      logic [6:0] row_count;
      logic       invert_pixels;
      logic [7:0] data_byte;
      logic [2:0] read_page;
      logic [6:0] read_column;
   } blit_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_data;
      logic       blit_done;
   } blit_result_type;

   typedef struct packed {
      blit_word_type   word;
      logic            known;
      blit_result_type result;
   } script_row_type;

   localparam blit_result_type NO_RESULT = '0;
   localparam int WORD_W = $bits(blit_word_type);

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_kind;
   logic [6:0] req_x_pos;
   logic [5:0] req_y_pos;
   logic [7:0] req_width_pixels;
   logic [6:0] req_row_count;
   logic req_invert_pixels;
   logic [7:0] req_data_byte;
   logic [2:0] req_read_page;
   logic [6:0] req_read_column;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_read_data;
   logic rsp_blit_done;
   logic csr_valid;
   logic csr_ready;
   logic csr_flip_mode;

   // word on the request port, plus a hand-typed expectation where the table has one
   blit_word_type req_word;
   logic req_known;
   blit_result_type req_known_result;

   assign req_kind          = req_word.kind;
   assign req_x_pos         = req_word.x_pos;
   assign req_y_pos         = req_word.y_pos;
   assign req_width_pixels  = req_word.width_pixels;
   assign req_row_count     = req_word.row_count;
   assign req_invert_pixels = req_word.invert_pixels;
   assign req_data_byte     = req_word.data_byte;
   assign req_read_page     = req_word.read_page;
   assign req_read_column   = req_word.read_column;

   page_bitmap_blit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the buffer and blit state
   logic [7:0] frame_copy [pbb_pkg::PAGES_DEF][pbb_pkg::COLUMNS_DEF];
   logic flip_copy = 1'b0;
   logic blit_on = 1'b0;
   logic invert_on = 1'b0;
   int col0 = 0;
   int page_now = 0;
   int row_bit = 0;
   int row_bytes = 0;
   int byte_idx = 0;
   int rows_to_go = 0;

   blit_result_type pending_results[$];
   int errors = 0;
   int results_seen = 0;
   int words_sent = 0;

   // sender pacing and receiver hold-off requests
   int burst_left = 0;
   int burst_max = 8;
   int gap_max = 3;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int rx_mode = 0;
   int rx_left = 0;

   script_row_type script[$];

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= 10)
         $display("%s", msg);
   endfunction

   // advance the shadow state by one accepted word and return its result
   function automatic blit_result_type apply_word(blit_word_type w);
      blit_result_type r;
      logic [7:0] pix;
      logic [7:0] mask;
      int base;
      int col;
      int i;
      r = '0;
      case (w.kind)
         pbb_pkg::KIND_START: begin
            if (w.width_pixels[2:0] != 3'd0) begin
               r.status = pbb_pkg::ST_BAD_WIDTH;
               blit_on = 1'b0;
            end else begin
               col0 = w.x_pos;
               page_now = w.y_pos[5:3];
               row_bit = w.y_pos[2:0];
               row_bytes = w.width_pixels[7:3];
               byte_idx = 0;
               rows_to_go = w.row_count;
               invert_on = w.invert_pixels;
               blit_on = (w.width_pixels != 8'd0) && (w.row_count != 7'd0);
            end
         end
         pbb_pkg::KIND_DATA: begin
            if (!blit_on) begin
               r.status = pbb_pkg::ST_NO_BLIT;
            end else begin
               pix = invert_on ? ~w.data_byte : w.data_byte;
               base = col0 + 8 * byte_idx;
               mask = 8'h01 << (flip_copy ? 7 - row_bit : row_bit);
               // msb of the byte is the leftmost column
               for (i = 0; i < 8; i++) begin
                  col = base + i;
                  if (col >= pbb_pkg::COLUMNS_DEF || page_now >= pbb_pkg::PAGES_DEF)
                     r.status = pbb_pkg::ST_CLIPPED;
                  else if (pix[7 - i])
                     frame_copy[page_now][col] = frame_copy[page_now][col] | mask;
                  else
                     frame_copy[page_now][col] = frame_copy[page_now][col] & ~mask;
               end
               // end of a bitmap row moves one pixel row down
               byte_idx++;
               if (byte_idx >= row_bytes) begin
                  byte_idx = 0;
                  row_bit++;
                  if (row_bit >= 8) begin
                     row_bit = 0;
                     page_now++;
                  end
                  rows_to_go--;
                  if (rows_to_go == 0) begin
                     blit_on = 1'b0;
                     r.blit_done = 1'b1;
                  end
               end
            end
         end
         // page and column fields cannot leave the default buffer
         pbb_pkg::KIND_READ: r.read_data = frame_copy[w.read_page][w.read_column];
         default: ;
      endcase
      return r;
   endfunction

   // accepted words and register writes feed the shadow state
   always @(posedge clock) begin
      blit_result_type predicted;
      if (!reset) begin
         if (csr_valid && csr_ready === 1'b1)
            flip_copy = csr_flip_mode;
         if (req_valid && req_stall === 1'b0) begin
            predicted = apply_word(req_word);
            if (req_known)
               pending_results.push_back(req_known_result);
            else
               pending_results.push_back(predicted);
         end
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      blit_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_error($sformatf("result %0d: none expected, got status %0d data %02h done %0d",
                                 results_seen, rsp_status, rsp_read_data, rsp_blit_done));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_read_data !== want.read_data ||
                rsp_blit_done !== want.blit_done)
               flag_error($sformatf({"result %0d: expected status %0d data %02h done %0d,",
                                     " got status %0d data %02h done %0d"},
                                    results_seen, want.status, want.read_data, want.blit_done,
                                    rsp_status, rsp_read_data, rsp_blit_done));
         end
      end
   end

   // receiver: long hold-offs on request, otherwise stall patterns of varying density
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_requests != hold_served) begin
         hold_served++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 7) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic blit_word_type any_word();
      blit_word_type w;
      w = WORD_W'({$urandom, $urandom});
      return w;
   endfunction

   function automatic blit_word_type start_word(logic [6:0] x, logic [5:0] y, logic [7:0] wd,
                                                logic [6:0] rows, logic inv);
      blit_word_type w;
      w = any_word();
      w.kind = pbb_pkg::KIND_START;
      w.x_pos = x;
      w.y_pos = y;
      w.width_pixels = wd;
      w.row_count = rows;
      w.invert_pixels = inv;
      return w;
   endfunction

   function automatic blit_word_type data_word(logic [7:0] d);
      blit_word_type w;
      w = any_word();
      w.kind = pbb_pkg::KIND_DATA;
      w.data_byte = d;
      return w;
   endfunction

   function automatic blit_word_type read_word(logic [2:0] pg, logic [6:0] col);
      blit_word_type w;
      w = any_word();
      w.kind = pbb_pkg::KIND_READ;
      w.read_page = pg;
      w.read_column = col;
      return w;
   endfunction

   function automatic blit_word_type spare_word();
      blit_word_type w;
      w = any_word();
      w.kind = KIND_SPARE;
      return w;
   endfunction

   function automatic blit_result_type outcome(logic [1:0] st, logic [7:0] rd, logic dn);
      blit_result_type r;
      r.status = st;
      r.read_data = rd;
      r.blit_done = dn;
      return r;
   endfunction

   task automatic add_checked_row(blit_word_type w, blit_result_type r);
      script.push_back({w, 1'b1, r});
   endtask

   task automatic add_row(blit_word_type w);
      script.push_back({w, 1'b0, NO_RESULT});
   endtask

   // offer one word, hold it until taken, then maybe end the burst with a gap
   task automatic send_word(blit_word_type w, logic known, blit_result_type r);
      int gap;
      req_word <= w;
      req_known <= known;
      req_known_result <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, gap_max);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, burst_max);
      end
   endtask

   // stop offering and wait until every expected result word is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_flip(logic v);
      drain();
      csr_flip_mode <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   // well-formed blit: start word, then its data words with read-backs mixed in
   task automatic blit_run();
      blit_word_type st;
      blit_word_type rd;
      int pick;
      int wd;
      int rows;
      int n;
      int i;
      pick = $urandom_range(0, 15);
      if (pick < 10)
         wd = 8 * $urandom_range(1, 4);
      else if (pick < 14)
         wd = 8 * $urandom_range(5, 16);
      else
         wd = 8 * $urandom_range(17, 31);
      if (wd > 32)
         rows = $urandom_range(1, 3);
      else if (wd == 8 && $urandom_range(0, 7) == 0)
         rows = $urandom_range(1, 127);
      else
         rows = $urandom_range(1, 10);
      n = (wd / 8) * rows;
      // cut short now and then, so the next start replaces a live blit
      if ($urandom_range(0, 7) == 0)
         n = $urandom_range(0, n - 1);
      st = start_word(7'($urandom), 6'($urandom), 8'(wd), 7'(rows), 1'($urandom));
      send_word(st, 1'b0, NO_RESULT);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            rd = read_word(3'($urandom), 7'($urandom));
            if ($urandom_range(0, 1) == 1) begin
               rd.read_page = st.y_pos[5:3];
               rd.read_column = st.x_pos + 7'($urandom_range(0, wd - 1));
            end
            send_word(rd, 1'b0, NO_RESULT);
         end
         send_word(data_word(8'($urandom)), 1'b0, NO_RESULT);
      end
   endtask

   // malformed or stray words
   task automatic noise_word();
      int wd;
      case ($urandom_range(0, 4))
         0: begin
            wd = $urandom_range(0, 255);
            if (wd % 8 == 0)
               wd = wd + $urandom_range(1, 7);
            send_word(start_word(7'($urandom), 6'($urandom), 8'(wd), 7'($urandom),
                                 1'($urandom)), 1'b0, NO_RESULT);
         end
         1: begin
            if ($urandom_range(0, 1) == 1)
               send_word(start_word(7'($urandom), 6'($urandom), 8'd0, 7'($urandom),
                                    1'($urandom)), 1'b0, NO_RESULT);
            else
               send_word(start_word(7'($urandom), 6'($urandom),
                                    8'(8 * $urandom_range(0, 31)),
                                    7'd0, 1'($urandom)), 1'b0, NO_RESULT);
         end
         2: send_word(data_word(8'($urandom)), 1'b0, NO_RESULT);
         3: send_word(spare_word(), 1'b0, NO_RESULT);
         default: send_word(read_word(3'($urandom), 7'($urandom)), 1'b0, NO_RESULT);
      endcase
   endtask

   initial begin
      int phase;
      int phase_end;
      int i;
      int j;
      bit held;
      bit paused;

      req_word <= '0;
      req_known <= 1'b0;
      req_known_result <= NO_RESULT;
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      csr_flip_mode <= 1'b0;
      reset <= 1'b1;
      for (i = 0; i < pbb_pkg::PAGES_DEF; i++)
         for (j = 0; j < pbb_pkg::COLUMNS_DEF; j++)
            frame_copy[i][j] = 8'h00;

      // directed words, run with flip_mode at its reset value
      add_checked_row(read_word(3'd0, 7'd0), outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(read_word(3'd7, 7'd127), outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(data_word(8'hFF), outcome(pbb_pkg::ST_NO_BLIT, 8'h00, 1'b0));
      add_checked_row(spare_word(), outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      // zero width, then zero rows: accepted but nothing to write
      add_checked_row(start_word(7'd0, 6'd0, 8'd0, 7'd5, 1'b0),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(data_word(8'h12), outcome(pbb_pkg::ST_NO_BLIT, 8'h00, 1'b0));
      add_checked_row(start_word(7'd3, 6'd9, 8'd16, 7'd0, 1'b0),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(data_word(8'h34), outcome(pbb_pkg::ST_NO_BLIT, 8'h00, 1'b0));
      // one byte, one row at the origin
      add_checked_row(start_word(7'd0, 6'd0, 8'd8, 7'd1, 1'b0),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(data_word(8'hFF), outcome(pbb_pkg::ST_OK, 8'h00, 1'b1));
      add_checked_row(read_word(3'd0, 7'd0), outcome(pbb_pkg::ST_OK, 8'h01, 1'b0));
      add_checked_row(read_word(3'd0, 7'd8), outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      // bottom right corner, inverted, running off the right edge
      add_checked_row(start_word(7'd124, 6'd63, 8'd16, 7'd1, 1'b1),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(data_word(8'h00), outcome(pbb_pkg::ST_CLIPPED, 8'h00, 1'b0));
      add_checked_row(data_word(8'h55), outcome(pbb_pkg::ST_CLIPPED, 8'h00, 1'b1));
      add_checked_row(read_word(3'd7, 7'd127), outcome(pbb_pkg::ST_OK, 8'h80, 1'b0));
      // full width and height, replaced by a wider blit before it ends
      add_checked_row(start_word(7'd0, 6'd60, 8'd128, 7'd64, 1'b0),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_row(data_word(8'hA5));
      add_checked_row(start_word(7'd127, 6'd0, 8'd248, 7'd127, 1'b0),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_checked_row(data_word(8'h3C), outcome(pbb_pkg::ST_CLIPPED, 8'h00, 1'b0));
      // bad width ends the live blit
      add_checked_row(start_word(7'd10, 6'd10, 8'd255, 7'd127, 1'b1),
                      outcome(pbb_pkg::ST_BAD_WIDTH, 8'h00, 1'b0));
      add_checked_row(data_word(8'hFF), outcome(pbb_pkg::ST_NO_BLIT, 8'h00, 1'b0));
      add_checked_row(start_word(7'd64, 6'd32, 8'd24, 7'd2, 1'b1),
                      outcome(pbb_pkg::ST_OK, 8'h00, 1'b0));
      add_row(data_word(8'h81));
      add_row(read_word(3'd4, 7'd65));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k])
         send_word(script[k].word, script[k].known, script[k].result);

      // random phases, flip_mode alternating from one end to the other
      held = 1'b0;
      paused = 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         set_flip(phase % 2 == 0);
         burst_max = (phase == 0) ? 100000 : $urandom_range(4, 40);
         gap_max = (phase == 2) ? 2 : $urandom_range(1, 10);
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            if (phase == 2 && !held && words_sent + 140 < phase_end) begin
               hold_requests++;
               held = 1'b1;
            end
            if (phase == 4 && !paused && words_sent + 100 < phase_end) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
               blit_run();
            else
               noise_word();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d expected result words never arrived",
                              pending_results.size()));
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
